[rtl/core/bpfm_pkg.sv]
// Types and codes shared by the buffer pool frame manager files.
package bpfm_pkg;

  // Request kinds
  localparam logic [2:0] KIND_GET_FIRST = 3'd0;
  localparam logic [2:0] KIND_GET_NEXT  = 3'd1;
  localparam logic [2:0] KIND_GET_THIS  = 3'd2;
  localparam logic [2:0] KIND_ALLOC     = 3'd3;
  localparam logic [2:0] KIND_DISPOSE   = 3'd4;
  localparam logic [2:0] KIND_UNPIN     = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_FD    = 3'd1;
  localparam logic [2:0] ST_NO_FRAME  = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_UNPINNED  = 3'd4;
  localparam logic [2:0] ST_FILE_FULL = 3'd5;

  localparam logic [2:0] PIN_MAX = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  file_id;
    logic [12:0] block_index;
    logic        dirty_mark;
  } bpfm_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic [12:0] result_block;
    logic        was_hit;
    logic        need_fetch;
    logic        need_writeback;
    logic [1:0]  evict_file;
    logic [12:0] evict_block;
  } bpfm_rsp_t;

  // One frame table entry; pinned holds one bit per file descriptor
  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [2:0]  pins;
    logic [31:0] stamp;
    logic [1:0]  owner;
    logic [12:0] block;
    logic [3:0]  pinned;
  } frame_t;

  // Bitmap search request and answer
  typedef struct packed {
    logic        start;
    logic [1:0]  file_id;
    logic [13:0] start_bit;
    logic        want;
    logic        single;
  } bm_req_t;

  typedef struct packed {
    logic        done;
    logic        found;
    logic [12:0] pos;
    logic [7:0]  data;
  } bm_rsp_t;

endpackage

[rtl/core/bpfm_bitmap.sv]
// Allocation bitmap memory with clearing pass and byte-serial bit search.
module bpfm_bitmap #(
  parameter int FILES        = 4,
  parameter int BITMAP_BYTES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpfm_pkg::bm_req_t  req_i,
  input  logic               we_i,
  input  logic [7:0]         wdata_i,
  output bpfm_pkg::bm_rsp_t  rsp_o,
  output logic               ready_o
);
  import bpfm_pkg::*;

  localparam int SCAN_BYTES = (BITMAP_BYTES < 1024) ? BITMAP_BYTES : 1024;
  localparam int SCAN_BITS  = SCAN_BYTES * 8;
  localparam int DEPTH      = FILES * SCAN_BYTES;
  localparam int AW         = $clog2(DEPTH);
  localparam int BW         = $clog2(SCAN_BYTES);

  localparam logic [1:0] B_CLR  = 2'd0;
  localparam logic [1:0] B_IDLE = 2'd1;
  localparam logic [1:0] B_RUN  = 2'd2;

  logic [7:0]    mem [DEPTH];
  logic [1:0]    st_q, st_d;
  logic [AW-1:0] clr_q, base_q, wa_q, ra, mwa;
  logic [BW-1:0] rp_q, db_q, first_q;
  logic [2:0]    sb_q, bit_sel;
  logic          want_q, single_q, iss_q, dv_q, issue, mwe;
  logic [7:0]    rdat_q, mask, cand, mwd;
  bm_rsp_t       rsp_q;

  assign issue   = (st_q == B_RUN) && iss_q;
  assign ra      = base_q + AW'(rp_q);
  assign ready_o = (st_q == B_IDLE);
  assign rsp_o   = rsp_q;

  assign mwe = (st_q == B_CLR) || ((st_q == B_IDLE) && we_i);
  assign mwa = (st_q == B_CLR) ? clr_q : wa_q;
  assign mwd = (st_q == B_CLR) ? 8'h00 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mem[mwa] <= mwd;
    end
    rdat_q <= mem[ra];
  end

  always_comb begin
    if (db_q == first_q) begin
      mask = single_q ? (8'h01 << sb_q) : (8'hFF << sb_q);
    end else begin
      mask = 8'hFF;
    end
    cand    = (want_q ? rdat_q : ~rdat_q) & mask;
    bit_sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cand[i]) begin
        bit_sel = 3'(i);
      end
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_CLR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          st_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (req_i.start && (req_i.start_bit < 14'(SCAN_BITS))) begin
          st_d = B_RUN;
        end
      end
      B_RUN: begin
        if (dv_q && ((cand != 8'h00) || single_q || (db_q == BW'(SCAN_BYTES - 1)))) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= B_CLR;
      clr_q <= '0;
      iss_q <= 1'b0;
      dv_q  <= 1'b0;
      rsp_q <= '0;
    end else begin
      st_q       <= st_d;
      dv_q       <= issue;
      rsp_q.done <= ((st_q == B_IDLE) && req_i.start &&
                     (req_i.start_bit >= 14'(SCAN_BITS))) ||
                    ((st_q == B_RUN) && (st_d == B_IDLE));
      if (st_q == B_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if ((st_q == B_IDLE) && req_i.start) begin
        if (req_i.start_bit >= 14'(SCAN_BITS)) begin
          // start point past the searched range: answer at once
          rsp_q.found <= 1'b0;
        end
        iss_q <= 1'b1;
      end
      if (issue && (single_q || (rp_q == BW'(SCAN_BYTES - 1)))) begin
        iss_q <= 1'b0;
      end
      if ((st_q == B_RUN) && (st_d == B_IDLE)) begin
        rsp_q.found <= (cand != 8'h00);
        rsp_q.pos   <= 13'({db_q, bit_sel});
        rsp_q.data  <= rdat_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    db_q <= rp_q;
    if ((st_q == B_IDLE) && req_i.start) begin
      base_q   <= AW'(32'(req_i.file_id) * SCAN_BYTES);
      rp_q     <= BW'(req_i.start_bit >> 3);
      first_q  <= BW'(req_i.start_bit >> 3);
      sb_q     <= req_i.start_bit[2:0];
      want_q   <= req_i.want;
      single_q <= req_i.single;
    end else if (issue && !single_q && (rp_q != BW'(SCAN_BYTES - 1))) begin
      rp_q <= rp_q + BW'(1);
    end
    if ((st_q == B_RUN) && (st_d == B_IDLE)) begin
      wa_q <= base_q + AW'(db_q);
    end
  end

endmodule

[rtl/core/buffer_pool_frame_manager.sv]
// Buffer pool frame manager top level: frame table, request sequencer, result register.
// Each request runs in three phases. First the allocation bitmap of the file is
// searched one byte per cycle from a synchronous memory: get_first and alloc start at
// block 0, get_next after block_index, and get_this and dispose read the single byte
// that holds block_index; a search covers at most min(BITMAP_BYTES, 1024) bytes. Then
// the frame table, a synchronous memory of FRAMES entries, is read one entry per cycle
// to find the buffered frame and the unpinned frame with the oldest stamp. Last, the
// commit state, once the output register is free, writes back the modified frame
// entry and bitmap byte and loads the result register. unpin skips the bitmap phase;
// a bad descriptor or an unknown kind goes straight to commit. One request is in
// flight at a time; the next one is accepted while the previous result still waits
// in the output register. After reset the bitmap memory is cleared, and during the
// clearing no request is taken; open_mask writes are taken at any time.
module buffer_pool_frame_manager #(
  parameter int FRAMES       = 16,
  parameter int FILES        = 4,
  parameter int BITMAP_BYTES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bpfm_pkg::bpfm_req_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bpfm_pkg::bpfm_rsp_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [3:0]           cfg_data_i
);
  import bpfm_pkg::*;

  localparam int SCAN_BYTES = (BITMAP_BYTES < 1024) ? BITMAP_BYTES : 1024;
  localparam int SCAN_BITS  = SCAN_BYTES * 8;
  localparam int FW         = $clog2(FRAMES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_BMAP   = 2'd1;
  localparam logic [1:0] S_FSCAN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]   st_q;
  logic [3:0]   open_mask_q;
  logic [31:0]  clock_q;
  logic         in_fire, commit, bm_ready;

  // request held for the whole sequence
  logic [2:0]   kind_q, err_q, err_d;
  logic [1:0]   fid_q;
  logic [12:0]  blk_q, tgt_q;
  logic         dm_q;

  // bitmap answer
  bm_req_t      bm_req;
  bm_rsp_t      bm_rsp;
  logic         found_q;
  logic [12:0]  pos_q;
  logic [7:0]   byte_q;
  logic         bm_we;
  logic [7:0]   bm_wdata;

  // frame table memory and scan
  frame_t        fmem [FRAMES];
  frame_t        frd_q, fe;
  logic [FRAMES-1:0] fok_q;
  logic          frd_ok_q;
  logic [FW:0]   fc_q;
  logic [FW-1:0] ri_q, fra, fwa;
  logic          rv_q, f_issue, fwe;
  frame_t        fwd, e;

  logic          hit_q, vic_ok_q, adv;
  logic [FW-1:0] hit_idx_q, vic_idx_q;
  frame_t        hit_e_q, vic_e_q;

  logic          out_valid_q;
  bpfm_rsp_t     out_q, rsp;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == S_IDLE) && bm_ready;
  assign in_fire     = in_valid_i && in_ready_o;
  assign commit      = (st_q == S_COMMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // check descriptor and kind at accept
  always_comb begin
    if (in_data_i.kind > KIND_UNPIN) begin
      err_d = ST_INVALID;
    end else if ((32'(in_data_i.file_id) >= FILES) || !open_mask_q[in_data_i.file_id]) begin
      err_d = ST_BAD_FD;
    end else begin
      err_d = ST_OK;
    end
  end

  always_comb begin
    bm_req.start     = in_fire && (err_d == ST_OK) && (in_data_i.kind != KIND_UNPIN);
    bm_req.file_id   = in_data_i.file_id;
    bm_req.want      = (in_data_i.kind != KIND_ALLOC);
    bm_req.single    = (in_data_i.kind == KIND_GET_THIS) || (in_data_i.kind == KIND_DISPOSE);
    priority case (in_data_i.kind)
      KIND_GET_NEXT: bm_req.start_bit = {1'b0, in_data_i.block_index} + 14'd1;
      KIND_GET_THIS, KIND_DISPOSE: bm_req.start_bit = {1'b0, in_data_i.block_index};
      default: bm_req.start_bit = 14'd0;
    endcase
  end

  bpfm_bitmap #(
    .FILES        (FILES),
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_bitmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bm_req),
    .we_i    (bm_we),
    .wdata_i (bm_wdata),
    .rsp_o   (bm_rsp),
    .ready_o (bm_ready)
  );

  // frame table: read one entry per cycle, write back once at commit
  assign f_issue = (st_q == S_FSCAN) && (fc_q < (FW+1)'(FRAMES));
  assign fra     = fc_q[FW-1:0];
  assign fe      = frd_ok_q ? frd_q : '0;

  always_ff @(posedge clk_i) begin
    if (fwe) begin
      fmem[fwa] <= fwd;
    end
    frd_q <= fmem[fra];
  end

  // commit: decide the result and the write-backs
  always_comb begin
    rsp      = '0;
    fwe      = 1'b0;
    fwa      = hit_idx_q;
    e        = hit_e_q;
    bm_we    = 1'b0;
    bm_wdata = byte_q;
    adv      = 1'b0;
    if (err_q != ST_OK) begin
      rsp.status = err_q;
    end else begin
      unique case (kind_q)
        KIND_GET_FIRST, KIND_GET_NEXT, KIND_GET_THIS: begin
          if (!found_q) begin
            rsp.status = ST_INVALID;
          end else if (!hit_q && !vic_ok_q) begin
            rsp.status = ST_NO_FRAME;
          end else begin
            if (hit_q) begin
              rsp.was_hit = 1'b1;
            end else begin
              // take the victim over for this block
              e   = vic_e_q;
              fwa = vic_idx_q;
              rsp.need_fetch = 1'b1;
              if (e.valid && e.dirty) begin
                rsp.need_writeback = 1'b1;
                rsp.evict_file     = e.owner;
                rsp.evict_block    = e.block;
              end
              e.valid  = 1'b1;
              e.dirty  = 1'b0;
              e.owner  = fid_q;
              e.block  = tgt_q;
              e.pinned = '0;
            end
            if (!e.pinned[fid_q]) begin
              e.pinned[fid_q] = 1'b1;
              if (e.pins != PIN_MAX) begin
                e.pins = e.pins + 3'd1;
              end
            end
            e.stamp = clock_q;
            fwe = 1'b1;
            adv = 1'b1;
            rsp.frame_index  = 4'(fwa);
            rsp.result_block = tgt_q;
          end
        end
        KIND_ALLOC: begin
          if (!vic_ok_q) begin
            rsp.status = ST_NO_FRAME;
          end else if (!found_q) begin
            rsp.status = ST_FILE_FULL;
          end else begin
            e   = vic_e_q;
            fwa = vic_idx_q;
            if (e.valid && e.dirty) begin
              rsp.need_writeback = 1'b1;
              rsp.evict_file     = e.owner;
              rsp.evict_block    = e.block;
            end
            e.valid  = 1'b1;
            e.dirty  = 1'b1;
            e.pins   = 3'd1;
            e.owner  = fid_q;
            e.block  = pos_q;
            e.pinned = 4'b0001 << fid_q;
            e.stamp  = clock_q;
            fwe      = 1'b1;
            adv      = 1'b1;
            bm_we    = 1'b1;
            bm_wdata = byte_q | (8'h01 << pos_q[2:0]);
            rsp.frame_index  = 4'(fwa);
            rsp.result_block = pos_q;
          end
        end
        KIND_DISPOSE: begin
          if ({1'b0, blk_q} >= 14'(SCAN_BITS)) begin
            rsp.status = ST_INVALID;
          end else if (hit_q && (hit_e_q.pins != 3'd0)) begin
            rsp.status = ST_INVALID;
          end else begin
            if (hit_q) begin
              e.valid = 1'b0;
              e.dirty = 1'b0;
              fwe     = 1'b1;
            end
            bm_we    = 1'b1;
            bm_wdata = byte_q & ~(8'h01 << blk_q[2:0]);
            rsp.result_block = blk_q;
          end
        end
        KIND_UNPIN: begin
          if (!hit_q) begin
            rsp.status = ST_INVALID;
          end else if (hit_e_q.pins == 3'd0) begin
            rsp.status = ST_UNPINNED;
          end else begin
            if (dm_q) begin
              e.dirty = 1'b1;
            end
            e.pins          = e.pins - 3'd1;
            e.pinned[fid_q] = 1'b0;
            fwe = 1'b1;
            rsp.frame_index  = 4'(fwa);
            rsp.result_block = blk_q;
          end
        end
        default: rsp.status = ST_INVALID;
      endcase
    end
    fwd = e;
    if (!commit) begin
      fwe   = 1'b0;
      bm_we = 1'b0;
      adv   = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      open_mask_q <= '0;
      clock_q     <= '0;
      fok_q       <= '0;
      frd_ok_q    <= 1'b0;
      rv_q        <= 1'b0;
      fc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        open_mask_q <= cfg_data_i;
      end
      frd_ok_q <= fok_q[fra];
      rv_q     <= f_issue;
      if (f_issue) begin
        fc_q <= fc_q + (FW+1)'(1);
      end
      if (fwe) begin
        fok_q[fwa] <= 1'b1;
      end
      if (adv) begin
        clock_q <= clock_q + 32'd1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_fire) begin
            fc_q <= '0;
            if (err_d != ST_OK) begin
              st_q <= S_COMMIT;
            end else if (in_data_i.kind == KIND_UNPIN) begin
              st_q <= S_FSCAN;
            end else begin
              st_q <= S_BMAP;
            end
          end
        end
        S_BMAP: begin
          if (bm_rsp.done) begin
            st_q <= S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (rv_q && (ri_q == FW'(FRAMES - 1))) begin
            st_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ri_q <= fra;
    if (in_fire) begin
      kind_q   <= in_data_i.kind;
      fid_q    <= in_data_i.file_id;
      blk_q    <= in_data_i.block_index;
      dm_q     <= in_data_i.dirty_mark;
      err_q    <= err_d;
      tgt_q    <= in_data_i.block_index;
      hit_q    <= 1'b0;
      vic_ok_q <= 1'b0;
    end
    if ((st_q == S_BMAP) && bm_rsp.done) begin
      found_q <= bm_rsp.found;
      pos_q   <= bm_rsp.pos;
      byte_q  <= bm_rsp.data;
      if ((kind_q == KIND_GET_FIRST) || (kind_q == KIND_GET_NEXT)) begin
        tgt_q <= bm_rsp.pos;
      end
    end
    if ((st_q == S_FSCAN) && rv_q) begin
      // first matching frame is the hit
      if (!hit_q && fe.valid && (fe.owner == fid_q) && (fe.block == tgt_q)) begin
        hit_q     <= 1'b1;
        hit_idx_q <= ri_q;
        hit_e_q   <= fe;
      end
      // oldest unpinned frame, lowest index on ties
      if ((fe.pins == 3'd0) && (!vic_ok_q || (fe.stamp < vic_e_q.stamp))) begin
        vic_ok_q  <= 1'b1;
        vic_idx_q <= ri_q;
        vic_e_q   <= fe;
      end
    end
    if (commit) begin
      out_q <= rsp;
    end
  end

endmodule

[rtl/core/bpfm_checker.sv]
// Port-level checks for the buffer pool frame manager, bound to the top level.
module bpfm_port_props (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input bpfm_pkg::bpfm_req_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input bpfm_pkg::bpfm_rsp_t  out_data_o
);
  import bpfm_pkg::*;

  // hold a stalled request beat
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("request beat dropped or changed while stalled");

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      (out_data_o.frame_index == 4'd0) && (out_data_o.result_block == 13'd0) &&
      !out_data_o.was_hit && !out_data_o.need_fetch && !out_data_o.need_writeback)
    else $error("error result carries nonzero fields");

  a_evict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.need_writeback |->
      (out_data_o.evict_file == 2'd0) && (out_data_o.evict_block == 13'd0))
    else $error("evict fields set without writeback");

  a_hit_no_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.was_hit |-> !out_data_o.need_fetch && !out_data_o.need_writeback)
    else $error("hit reports fetch or writeback");

endmodule

bind buffer_pool_frame_manager bpfm_port_props u_bpfm_port_props (.*);

[tb/bpfm_checker.sv]
// Scoreboard for the buffer pool frame manager: watches the channels, predicts, compares.
`timescale 1ns / 1ps
module bpfm_checker
  import bpfm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  bpfm_req_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  bpfm_rsp_t  out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [3:0] cfg_data_i,
  output int         pending_o,
  output int         fail_count_o
);

  localparam int NFRAMES = 16;
  localparam int NFILES  = 4;
  localparam int NBITS   = 8192;

  logic [3:0]  open_files;
  logic        fr_valid  [NFRAMES];
  logic        fr_dirty  [NFRAMES];
  logic [2:0]  fr_pins   [NFRAMES];
  logic [31:0] fr_stamp  [NFRAMES];
  logic [1:0]  fr_owner  [NFRAMES];
  logic [12:0] fr_block  [NFRAMES];
  logic [15:0] file_pins [NFILES];
  logic        used_bits [NFILES][NBITS];
  logic [31:0] lru_clock;

  bpfm_rsp_t expected_rsp_q[$];

  assign pending_o = expected_rsp_q.size();

  function automatic int find_frame(logic [1:0] f, logic [12:0] blk);
    for (int i = 0; i < NFRAMES; i++)
      if (fr_valid[i] && fr_owner[i] == f && fr_block[i] == blk) return i;
    return -1;
  endfunction

  // oldest unpinned frame, lowest index on ties
  function automatic int oldest_free();
    int v;
    v = -1;
    for (int i = 0; i < NFRAMES; i++)
      if (fr_pins[i] == 0 && (v < 0 || fr_stamp[i] < fr_stamp[v])) v = i;
    return v;
  endfunction

  function automatic int first_bit(logic [1:0] f, int start, logic want);
    for (int i = start; i < NBITS; i++)
      if (used_bits[f][i] == want) return i;
    return -1;
  endfunction

  function automatic void take_frame(int v, logic [1:0] f, logic [12:0] blk,
                                     inout bpfm_rsp_t r);
    if (fr_valid[v] && fr_dirty[v]) begin
      r.need_writeback = 1'b1;
      r.evict_file     = fr_owner[v];
      r.evict_block    = fr_block[v];
    end
    for (int k = 0; k < NFILES; k++) file_pins[k][v] = 1'b0;
    fr_valid[v] = 1'b1;
    fr_dirty[v] = 1'b0;
    fr_owner[v] = f;
    fr_block[v] = blk;
  endfunction

  function automatic void access_block(logic [1:0] f, logic [12:0] blk,
                                       inout bpfm_rsp_t r);
    int fr;
    fr = find_frame(f, blk);
    if (fr < 0) begin
      fr = oldest_free();
      if (fr < 0) begin
        r.status = ST_NO_FRAME;
        return;
      end
      take_frame(fr, f, blk, r);
      r.need_fetch = 1'b1;
    end else begin
      r.was_hit = 1'b1;
    end
    if (!file_pins[f][fr]) begin
      file_pins[f][fr] = 1'b1;
      if (fr_pins[fr] < PIN_MAX) fr_pins[fr]++;
    end
    fr_stamp[fr]   = lru_clock;
    lru_clock      = lru_clock + 1;
    r.frame_index  = fr[3:0];
    r.result_block = blk;
  endfunction

  function automatic bpfm_rsp_t serve_request(bpfm_req_t q);
    bpfm_rsp_t r;
    int pos;
    int fr;
    r = '0;
    if (q.kind > KIND_UNPIN) begin
      r.status = ST_INVALID;
      return r;
    end
    if (!open_files[q.file_id]) begin
      r.status = ST_BAD_FD;
      return r;
    end
    case (q.kind)
      KIND_GET_FIRST, KIND_GET_NEXT: begin
        pos = first_bit(q.file_id, (q.kind == KIND_GET_FIRST) ? 0 : q.block_index + 1, 1'b1);
        if (pos < 0) r.status = ST_INVALID;
        else access_block(q.file_id, pos[12:0], r);
      end
      KIND_GET_THIS: begin
        if (!used_bits[q.file_id][q.block_index]) r.status = ST_INVALID;
        else access_block(q.file_id, q.block_index, r);
      end
      KIND_ALLOC: begin
        fr = oldest_free();
        if (fr < 0) begin
          r.status = ST_NO_FRAME;
        end else begin
          pos = first_bit(q.file_id, 0, 1'b0);
          if (pos < 0) begin
            r.status = ST_FILE_FULL;
          end else begin
            used_bits[q.file_id][pos] = 1'b1;
            take_frame(fr, q.file_id, pos[12:0], r);
            fr_dirty[fr] = 1'b1;
            fr_pins[fr]  = 3'd1;
            file_pins[q.file_id][fr] = 1'b1;
            fr_stamp[fr]   = lru_clock;
            lru_clock      = lru_clock + 1;
            r.frame_index  = fr[3:0];
            r.result_block = pos[12:0];
          end
        end
      end
      KIND_DISPOSE: begin
        fr = find_frame(q.file_id, q.block_index);
        if (fr >= 0 && fr_pins[fr] != 0) begin
          r.status = ST_INVALID;
        end else begin
          if (fr >= 0) begin
            fr_valid[fr] = 1'b0;
            fr_dirty[fr] = 1'b0;
          end
          used_bits[q.file_id][q.block_index] = 1'b0;
          r.result_block = q.block_index;
        end
      end
      default: begin
        fr = find_frame(q.file_id, q.block_index);
        if (fr < 0) begin
          r.status = ST_INVALID;
        end else if (fr_pins[fr] == 0) begin
          r.status = ST_UNPINNED;
        end else begin
          if (q.dirty_mark) fr_dirty[fr] = 1'b1;
          fr_pins[fr]--;
          file_pins[q.file_id][fr] = 1'b0;
          r.frame_index  = fr[3:0];
          r.result_block = q.block_index;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bpfm_rsp_t exp_rsp;
    if (!rst_ni) begin
      open_files = '0;
      lru_clock  = '0;
      for (int i = 0; i < NFRAMES; i++) begin
        fr_valid[i] = 0; fr_dirty[i] = 0; fr_pins[i] = '0;
        fr_stamp[i] = '0; fr_owner[i] = '0; fr_block[i] = '0;
      end
      for (int f = 0; f < NFILES; f++) begin
        file_pins[f] = '0;
        for (int b = 0; b < NBITS; b++) used_bits[f][b] = 1'b0;
      end
      expected_rsp_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) open_files = cfg_data_i;
      // check the outgoing beat before queuing the one coming in
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result beat with no request outstanding: %p", out_data_i);
          fail_count_o++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (out_data_i.status != exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, out_data_i.status);
            fail_count_o++;
          end
          if (out_data_i.frame_index != exp_rsp.frame_index) begin
            $error("frame_index: expected %0d, got %0d",
                   exp_rsp.frame_index, out_data_i.frame_index);
            fail_count_o++;
          end
          if (out_data_i.result_block != exp_rsp.result_block) begin
            $error("result_block: expected %0d, got %0d",
                   exp_rsp.result_block, out_data_i.result_block);
            fail_count_o++;
          end
          if (out_data_i.was_hit != exp_rsp.was_hit) begin
            $error("was_hit: expected %0d, got %0d", exp_rsp.was_hit, out_data_i.was_hit);
            fail_count_o++;
          end
          if (out_data_i.need_fetch != exp_rsp.need_fetch) begin
            $error("need_fetch: expected %0d, got %0d",
                   exp_rsp.need_fetch, out_data_i.need_fetch);
            fail_count_o++;
          end
          if (out_data_i.need_writeback != exp_rsp.need_writeback) begin
            $error("need_writeback: expected %0d, got %0d",
                   exp_rsp.need_writeback, out_data_i.need_writeback);
            fail_count_o++;
          end
          if (out_data_i.evict_file != exp_rsp.evict_file) begin
            $error("evict_file: expected %0d, got %0d",
                   exp_rsp.evict_file, out_data_i.evict_file);
            fail_count_o++;
          end
          if (out_data_i.evict_block != exp_rsp.evict_block) begin
            $error("evict_block: expected %0d, got %0d",
                   exp_rsp.evict_block, out_data_i.evict_block);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_rsp_q.push_back(serve_request(in_data_i));
    end
  end

endmodule

[tb/testbench.sv]
// Top of the buffer pool frame manager testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import bpfm_pkg::*;

  // The two kind codes the block does not define
  localparam logic [2:0] KIND_UNDEF_LO = 3'd6;
  localparam logic [2:0] KIND_UNDEF_HI = 3'd7;
  localparam int IDLE_PCT    = 31;
  localparam int RAND_ITEMS  = 700;
  localparam int DRAIN_TICKS = 64;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  bpfm_req_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  bpfm_rsp_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;
  int         pending;
  int         fail_count;
  // set while both sides run flat out
  logic       no_idle = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  buffer_pool_frame_manager u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  bpfm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Stall the result side at random, except during the flat-out stretch
  always @(posedge clk_i) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Push one request beat; hold valid and payload until it is taken.
  // Valid is left high after the beat so back-to-back beats need no second
  // assignment in one step; the idle loop lowers it when a gap is drawn.
  task automatic push_request(input bpfm_req_t req);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic push_op(input logic [2:0] kind, input logic [1:0] file_id,
                         input logic [12:0] blk, input logic dirty);
    bpfm_req_t req;
    req.kind        = kind;
    req.file_id     = file_id;
    req.block_index = blk;
    req.dirty_mark  = dirty;
    push_request(req);
  endtask

  // Drain all results, let the block settle, then write open_mask
  task automatic set_open_mask(input logic [3:0] mask);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small block numbers so hits, evictions and writebacks recur;
  // some full-range numbers so every index bit toggles.
  function automatic bpfm_req_t random_request();
    bpfm_req_t req;
    int pick;
    pick = $urandom_range(99);
    if      (pick < 25) req.kind = KIND_ALLOC;
    else if (pick < 45) req.kind = KIND_GET_THIS;
    else if (pick < 53) req.kind = KIND_GET_FIRST;
    else if (pick < 61) req.kind = KIND_GET_NEXT;
    else if (pick < 83) req.kind = KIND_UNPIN;
    else if (pick < 95) req.kind = KIND_DISPOSE;
    else req.kind = ($urandom_range(1)) ? KIND_UNDEF_HI : KIND_UNDEF_LO;
    req.file_id     = 2'($urandom_range(3));
    req.block_index = ($urandom_range(99) < 85) ? 13'($urandom_range(23))
                                                 : 13'($urandom_range(8191));
    req.dirty_mark  = 1'($urandom_range(1));
    return req;
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: every descriptor closed, then all open
    set_open_mask(4'h0);
    push_op(KIND_GET_FIRST, 2'd0, 13'd0, 1'b0);
    push_op(KIND_ALLOC, 2'd3, 13'd0, 1'b0);
    set_open_mask(4'hF);
    push_op(KIND_UNDEF_LO, 2'd0, 13'd0, 1'b0);
    push_op(KIND_UNDEF_HI, 2'd3, 13'h1FFF, 1'b1);
    push_op(KIND_GET_FIRST, 2'd1, 13'd0, 1'b0);          // empty bitmap
    push_op(KIND_GET_THIS, 2'd1, 13'h1FFF, 1'b0);        // clear bit
    push_op(KIND_UNPIN, 2'd1, 13'd5, 1'b0);              // not buffered
    push_op(KIND_DISPOSE, 2'd2, 13'h1FFF, 1'b1);         // top block, not buffered
    // Pin all frames from one file, then one more alloc finds no free frame
    for (int i = 0; i < 17; i++) push_op(KIND_ALLOC, 2'd0, 13'd0, 1'b0);
    push_op(KIND_GET_THIS, 2'd2, 13'd0, 1'b0);
    push_op(KIND_DISPOSE, 2'd0, 13'd3, 1'b0);            // still pinned
    push_op(KIND_UNPIN, 2'd0, 13'd0, 1'b1);              // release and dirty
    push_op(KIND_UNPIN, 2'd0, 13'd0, 1'b0);              // no pins left
    push_op(KIND_GET_NEXT, 2'd0, 13'd2, 1'b0);           // hit on block 3
    push_op(KIND_GET_THIS, 2'd0, 13'd0, 1'b0);           // hit on unpinned frame
    push_op(KIND_UNPIN, 2'd0, 13'd0, 1'b1);
    push_op(KIND_ALLOC, 2'd3, 13'd0, 1'b0);              // evicts dirty block 0
    push_op(KIND_GET_NEXT, 2'd0, 13'h1FFF, 1'b0);        // nothing past the end

    // Random part in phases with different descriptor masks
    for (int i = 0; i < RAND_ITEMS; i++) begin
      case (i)
        150: set_open_mask(4'b0101);
        300: set_open_mask(4'b1010);
        450: set_open_mask(4'hF);
        default: ;
      endcase
      no_idle <= (i >= 500 && i < 600);
      push_request(random_request());
    end

    in_valid <= 1'b0;
    no_idle  <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[buffer_pool_frame_manager.f]
rtl/core/bpfm_pkg.sv
rtl/core/bpfm_bitmap.sv
rtl/core/buffer_pool_frame_manager.sv
rtl/core/bpfm_checker.sv
tb/bpfm_checker.sv
tb/testbench.sv
